/* rtl/wfg_pkg.sv */
// Shared types, constants and the sine table function for the waveform generator.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package wfg_pkg;

    // System constants
    localparam int CLOCK_HZ   = 2000000;
    localparam int ANGLE_BITS = 12;

    // Field widths
    localparam int FREQ_W   = 21;
    localparam int TIMER_W  = 16;
    localparam int SAMPLE_W = 12;
    localparam int MAG_W    = 11;
    localparam int RAMP_W   = 13;

    // Derived widths for the divide unit
    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int DIVR_W = (CLK_W > FREQ_W) ? CLK_W : FREQ_W;
    localparam int DVD_W  = (CLK_W > TIMER_W) ? CLK_W : TIMER_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    // Quarter-wave table geometry
    localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
    localparam int ADDR_W  = ANGLE_BITS - 1;

    // Waveform constants
    localparam int MID_LEVEL  = 2047;
    localparam int FULL_SCALE = 4095;
    localparam int RAMP_STEP  = 50;
    localparam int SAW_STEP   = 10;
    localparam int FREQ_RESET = 1000;

    // Fixed-point sine series constants
    localparam logic [63:0] PIHALF_Q40 = 64'h0000_0192_1FB5_4443;
    localparam int FRAC_BITS    = 40;
    localparam int QMUL_SHIFT   = 20;
    localparam int TAYLOR_TERMS = 20;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 1'b1;

    typedef enum logic [1:0] {
        MODE_SINE = 2'd0,
        MODE_TRI  = 2'd1,
        MODE_SAW  = 2'd2,
        MODE_OFF  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DIV_PERIOD = 2'd0,
        DIV_PHASE  = 2'd1,
        DIV_ANGLE  = 2'd2
    } div_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    tri_step;
        logic    saw_step;
        logic    mid_load;
        logic    div_start;
        div_op_t div_op;
        logic    period_load;
        logic    rom_read;
        logic    sine_load;
        logic    out_load;
    } wfg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  freq_zero;
        logic  div_done;
        logic  period_zero;
    } wfg_status_t;

    // Truncating Q40 multiply, split into two partial products
    function automatic logic [63:0] qmul_f(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = a >> QMUL_SHIFT;
        lo = a & ((64'd1 << QMUL_SHIFT) - 64'd1);
        return (hi * b + ((lo * b) >> QMUL_SHIFT)) >> QMUL_SHIFT;
    endfunction

    // Unsigned 64-bit quotient by shift and subtract, for table build only
    function automatic logic [63:0] udiv_f(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = num;
        for (int b = 0; b < 64; b++)
        begin
            rem = {rem[63:0], quo[63]};
            quo = {quo[62:0], 1'b0};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave magnitude, evaluated at elaboration for the table
    function automatic logic [MAG_W-1:0] sine_mag_f(input int unsigned r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        fact_step;
        logic signed [63:0] acc;
        logic [63:0]        v;
        x    = (64'(r) * PIHALF_Q40) >> (ANGLE_BITS - 2);
        x2   = qmul_f(x, x);
        term = x;
        acc  = $signed(x);
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            if (term != 64'd0) begin
                fact_step = 64'((2 * n) * (2 * n + 1));
                term      = udiv_f(qmul_f(term, x2), fact_step);
                if ((n % 2) == 1)
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
        end
        if (acc < 0)
            acc = 64'sd0;
        v = ($unsigned(acc) * 64'(MID_LEVEL) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (v > 64'(MID_LEVEL))
            v = 64'(MID_LEVEL);
        return v[MAG_W-1:0];
    endfunction

endpackage

/* rtl/wfg_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on wfg_pkg for its widths.
`timescale 1ns / 1ps

module wfg_div
    import wfg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CNT_W-1:0]  steps,
    input  logic [DIVR_W-1:0] rem_init,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [DVD_W-1:0]  quotient,
    output logic [DIVR_W-1:0] remainder
);

    localparam int REM_W = DIVR_W + 1;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DIVR_W-1:0] divr_reg;

    logic [REM_W-1:0]  shifted;
    logic              fits;
    logic [REM_W-1:0]  rem_next;
    logic [DVD_W-1:0]  dvd_next;

    // One trial subtraction
    always_comb
    begin
        shifted  = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
        fits     = (shifted >= {1'b0, divr_reg});
        rem_next = fits ? (shifted - {1'b0, divr_reg}) : shifted;
        dvd_next = {dvd_reg[DVD_W-2:0], fits};
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= REM_W'(rem_init);
            dvd_reg  <= dividend;
            divr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg[DIVR_W-1:0];

endmodule

/* rtl/wfg_sine_rom.sv */
// Quarter-wave sine magnitude ROM with registered read.
// Depends on wfg_pkg for the table function and geometry.
`timescale 1ns / 1ps

module wfg_sine_rom
    import wfg_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    output logic [MAG_W-1:0]  mag
);

    logic [MAG_W-1:0] rom_mem [0:QUARTER];
    logic [MAG_W-1:0] mag_reg;

    // Table contents fixed at elaboration
    for (genvar i = 0; i <= QUARTER; i++)
    begin : g_entry
        localparam logic [MAG_W-1:0] ENTRY = sine_mag_f(i);
        assign rom_mem[i] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mag_reg <= rom_mem[addr];
    end

    assign mag = mag_reg;

endmodule

/* rtl/wfg_datapath.sv */
// Datapath: configuration registers, ramp and sawtooth state, divider, sine table, output.
// Depends on wfg_pkg, wfg_div and wfg_sine_rom.
`timescale 1ns / 1ps

module wfg_datapath
    import wfg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FREQ_W-1:0]    cfg_data,
    input  logic [TIMER_W-1:0]   timer_value,
    input  wfg_cmd_t             cmd,
    output wfg_status_t          status,
    output logic [SAMPLE_W-1:0]  dac_sample
);

    mode_t               mode_reg;
    logic [FREQ_W-1:0]   freq_reg;
    logic [TIMER_W-1:0]  timer_reg;
    logic [RAMP_W-1:0]   ramp_level_reg;
    logic                ramp_rising_reg;
    logic [SAMPLE_W-1:0] saw_level_reg;
    logic [CLK_W-1:0]    period_reg;
    logic [1:0]          quad_reg;
    logic [SAMPLE_W-1:0] result_reg;
    logic [SAMPLE_W-1:0] dac_sample_reg;

    logic [RAMP_W-1:0]   ramp_up;
    logic [RAMP_W-1:0]   ramp_level_next;
    logic                ramp_rising_next;
    logic [SAMPLE_W-1:0] tri_sample;
    logic [SAMPLE_W:0]   saw_sum;
    logic [SAMPLE_W-1:0] saw_level_next;

    logic                div_done;
    logic [DVD_W-1:0]    div_quotient;
    logic [DIVR_W-1:0]   div_remainder;
    logic [CNT_W-1:0]    div_steps;
    logic [DIVR_W-1:0]   div_rem_init;
    logic [DVD_W-1:0]    div_dividend;
    logic [DIVR_W-1:0]   div_divisor;

    logic [ANGLE_BITS-1:0] angle;
    logic [ADDR_W-1:0]     rom_addr;
    logic [MAG_W-1:0]      rom_mag;
    logic [SAMPLE_W-1:0]   sine_sample;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SINE;
            freq_reg <= FREQ_W'(FREQ_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE: mode_reg <= mode_t'(cfg_data[1:0]);
                CFG_FREQ: freq_reg <= cfg_data;
            endcase
        end
    end

    // Triangle step: up by 50 to the top, down by 50 to zero
    always_comb
    begin
        ramp_up = ramp_level_reg + RAMP_W'(RAMP_STEP);
        if (ramp_rising_reg)
        begin
            ramp_level_next  = ramp_up;
            ramp_rising_next = !(ramp_up >= RAMP_W'(FULL_SCALE));
        end
        else
        begin
            ramp_level_next  = (ramp_level_reg >= RAMP_W'(RAMP_STEP)) ?
                               (ramp_level_reg - RAMP_W'(RAMP_STEP)) : '0;
            ramp_rising_next = (ramp_level_next == '0);
        end
        tri_sample = (ramp_level_next > RAMP_W'(FULL_SCALE)) ?
                     SAMPLE_W'(FULL_SCALE) : ramp_level_next[SAMPLE_W-1:0];
    end

    // Sawtooth step with wrap at full scale
    always_comb
    begin
        saw_sum        = {1'b0, saw_level_reg} + (SAMPLE_W + 1)'(SAW_STEP);
        saw_level_next = (saw_sum >= (SAMPLE_W + 1)'(FULL_SCALE)) ? '0 : saw_sum[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_level_reg  <= '0;
            ramp_rising_reg <= 1'b1;
            saw_level_reg   <= '0;
        end
        else
        begin
            if (cmd.tri_step)
            begin
                ramp_level_reg  <= ramp_level_next;
                ramp_rising_reg <= ramp_rising_next;
            end
            if (cmd.saw_step)
                saw_level_reg <= saw_level_next;
        end
    end

    // Divider operand selection: period, timer phase, then angle
    always_comb
    begin
        div_steps    = CNT_W'(DVD_W);
        div_rem_init = '0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (cmd.div_op)
            DIV_PERIOD:
            begin
                div_dividend = DVD_W'(CLOCK_HZ);
                div_divisor  = DIVR_W'(freq_reg);
            end
            DIV_PHASE:
            begin
                div_dividend = DVD_W'(timer_reg);
                div_divisor  = DIVR_W'(div_quotient[CLK_W-1:0]);
            end
            DIV_ANGLE:
            begin
                div_steps    = CNT_W'(ANGLE_BITS);
                div_rem_init = div_remainder;
                div_divisor  = DIVR_W'(period_reg);
            end
            default:
            begin
                div_steps = CNT_W'(DVD_W);
            end
        endcase
    end

    wfg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .steps     (div_steps),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Fold the angle into the first quadrant
    always_comb
    begin
        angle = div_quotient[ANGLE_BITS-1:0];
        if (angle[ANGLE_BITS-2])
            rom_addr = ADDR_W'(QUARTER) - {1'b0, angle[ANGLE_BITS-3:0]};
        else
            rom_addr = {1'b0, angle[ANGLE_BITS-3:0]};
    end

    wfg_sine_rom u_rom (
        .clk   (clk),
        .rd_en (cmd.rom_read),
        .addr  (rom_addr),
        .mag   (rom_mag)
    );

    // Lower half-cycle subtracts the magnitude from mid-scale
    assign sine_sample = quad_reg[1] ?
                         (SAMPLE_W'(MID_LEVEL) - SAMPLE_W'(rom_mag)) :
                         (SAMPLE_W'(MID_LEVEL) + SAMPLE_W'(rom_mag));

    // Operand capture, result staging and output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            timer_reg <= timer_value;
        if (cmd.period_load)
            period_reg <= div_quotient[CLK_W-1:0];
        if (cmd.rom_read)
            quad_reg <= angle[ANGLE_BITS-1:ANGLE_BITS-2];

        priority if (cmd.tri_step)
            result_reg <= tri_sample;
        else if (cmd.saw_step)
            result_reg <= saw_level_next;
        else if (cmd.mid_load)
            result_reg <= SAMPLE_W'(MID_LEVEL);
        else if (cmd.sine_load)
            result_reg <= sine_sample;

        if (cmd.out_load)
            dac_sample_reg <= result_reg;
    end

    always_comb
    begin
        status.mode        = mode_reg;
        status.freq_zero   = (freq_reg == '0);
        status.div_done    = div_done;
        status.period_zero = (div_quotient == '0);
    end

    assign dac_sample = dac_sample_reg;

endmodule

/* rtl/wfg_ctrl.sv */
// Controller state machine: input/output handshakes and sequencing of the datapath.
// Depends on wfg_pkg for the command and status structs.
`timescale 1ns / 1ps

module wfg_ctrl
    import wfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        overflow_event,
    output logic        sample_valid,
    input  logic        sample_ready,
    input  wfg_status_t status,
    output wfg_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_PHASE,
        ST_ANGLE,
        ST_SINE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_PERIOD;
        item_ready = 1'b0;
        valid_next = valid_reg && !sample_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    if (overflow_event)
                    begin
                        unique case (status.mode)
                            MODE_SINE:
                            begin
                                if (status.freq_zero)
                                begin
                                    cmd.mid_load = 1'b1;
                                    state_next   = ST_EMIT;
                                end
                                else
                                begin
                                    cmd.div_start = 1'b1;
                                    cmd.div_op    = DIV_PERIOD;
                                    state_next    = ST_PERIOD;
                                end
                            end
                            MODE_TRI:
                            begin
                                cmd.tri_step = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            MODE_SAW:
                            begin
                                cmd.saw_step = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            MODE_OFF:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            // Period = clock rate / frequency
            ST_PERIOD:
            begin
                if (status.div_done)
                begin
                    cmd.period_load = 1'b1;
                    if (status.period_zero)
                    begin
                        cmd.mid_load = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = DIV_PHASE;
                        state_next    = ST_PHASE;
                    end
                end
            end

            // Timer count modulo period
            ST_PHASE:
            begin
                cmd.div_op = DIV_PHASE;
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_ANGLE;
                    state_next    = ST_ANGLE;
                end
            end

            // Angle fraction, then table read
            ST_ANGLE:
            begin
                cmd.div_op = DIV_ANGLE;
                if (status.div_done)
                begin
                    cmd.rom_read = 1'b1;
                    state_next   = ST_SINE;
                end
            end

            ST_SINE:
            begin
                cmd.sine_load = 1'b1;
                state_next    = ST_EMIT;
            end

            // Wait for the output register to be free
            ST_EMIT:
            begin
                if (!valid_reg || sample_ready)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign sample_valid = valid_reg;

endmodule

/* rtl/three_mode_waveform_generator_top.sv */
// Top level of the three-mode waveform generator (sine, triangle, sawtooth).
// Depends on wfg_pkg, wfg_ctrl and wfg_datapath.
//
//  Channel   Handshake                 Payload
//  -------   ------------------------  ---------------------------------
//  item      item_valid / item_ready   overflow_event, timer_value
//  sample    sample_valid/sample_ready dac_sample
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Ignored transactions (no overflow, or mode 3) are accepted without leaving idle;
// triangle and sawtooth pass through the emit state. Sine runs the bit-per-cycle
// divider three times in turn (period, phase, angle), then reads the sine table.
// Reset is asynchronous and active low; no clearing pass is needed after it.
// A finished sample waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module three_mode_waveform_generator_top
    import wfg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 overflow_event,
    input  logic [TIMER_W-1:0]   timer_value,

    output logic                 sample_valid,
    input  logic                 sample_ready,
    output logic [SAMPLE_W-1:0]  dac_sample,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FREQ_W-1:0]    cfg_data
);

    wfg_cmd_t    cmd;
    wfg_status_t status;

    // Registers accept writes at any time
    assign cfg_ready = 1'b1;

    wfg_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .overflow_event (overflow_event),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .status         (status),
        .cmd            (cmd)
    );

    wfg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .timer_value (timer_value),
        .cmd         (cmd),
        .status      (status),
        .dac_sample  (dac_sample)
    );

endmodule

/* tb/three_mode_waveform_generator_top_test.sv */
// Self-checking bench for three_mode_waveform_generator_top. It drives directed and random
// timer events through valid/ready and checks every DAC sample against an in-bench model.
// Depends on wfg_pkg and the generator RTL.
`timescale 1ns / 1ps

module three_mode_waveform_generator_top_test;
    import wfg_pkg::*;

    // Generator constants, kept local to the bench
    localparam logic [63:0] COUNTS_PER_SEC = 64'd2000000;
    localparam int          PHASE_BITS     = 12;
    localparam logic [63:0] HALF_PI_Q40    = 64'h0000_0192_1FB5_4443;
    localparam logic [63:0] MID_CODE       = 64'd2047;
    localparam int          TRI_STEP       = 50;
    localparam int          SAW_INC        = 10;
    localparam int          TOP_CODE       = 4095;

    localparam int SETTLE_CYCLES = 80;
    // two rounds of random phases, about 850 transactions with the directed ones
    localparam int TARGET_TICKS  = 600;

    typedef struct packed {
        logic               overflow;
        logic [TIMER_W-1:0] timer;
    } tick_t;

    // DUT ports
    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 item_valid     = 1'b0;
    logic                 item_ready;
    logic                 overflow_event = 1'b0;
    logic [TIMER_W-1:0]   timer_value    = '0;
    logic                 sample_valid;
    logic                 sample_ready   = 1'b0;
    logic [SAMPLE_W-1:0]  dac_sample;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_MODE;
    logic [FREQ_W-1:0]    cfg_data       = '0;

    // Bench copy of the generator registers and ramp state
    mode_t              mode_reg    = MODE_SINE;
    logic [FREQ_W-1:0]  freq_reg    = 21'd1000;
    logic [RAMP_W-1:0]  ramp_level  = '0;
    logic               ramp_rising = 1'b1;
    logic [SAMPLE_W-1:0] saw_level  = '0;

    tick_t               tick_queue[$];
    logic [SAMPLE_W-1:0] samples_due[$];
    int unsigned         ticks_unaccepted = 0;
    int unsigned         mismatch_count   = 0;

    // Traffic shaping; the two styles are changed only between phases
    int unsigned send_style   = 0;
    int unsigned accept_style = 0;
    int unsigned gap_left     = 0;
    int unsigned burst_left   = 1;
    int unsigned stall_phase  = 0;

    three_mode_waveform_generator_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .overflow_event (overflow_event),
        .timer_value    (timer_value),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .dac_sample     (dac_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Truncating Q40 product, first operand split to stay inside 64 bits
    function automatic logic [63:0] q40_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] upper;
        logic [63:0] lower;
        upper = a >> 20;
        lower = a & 64'hF_FFFF;
        return (upper * b + ((lower * b) >> 20)) >> 20;
    endfunction

    // First-quadrant sine magnitude by Taylor series, scaled to 0..2047
    function automatic logic [63:0] quarter_mag(input logic [63:0] r);
        logic [63:0]        x;
        logic [63:0]        x_sq;
        logic [63:0]        term;
        logic [63:0]        scaled;
        logic signed [63:0] series;
        int                 n;
        x      = (r * HALF_PI_Q40) >> (PHASE_BITS - 2);
        x_sq   = q40_mul(x, x);
        term   = x;
        series = $signed(x);
        n      = 1;
        while (n < 20 && term != 64'd0)
        begin
            term = q40_mul(term, x_sq) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
                series = series - $signed(term);
            else
                series = series + $signed(term);
            n++;
        end
        if (series < 0)
            series = '0;
        scaled = (64'(series) * MID_CODE + (64'd1 << 39)) >> 40;
        return (scaled > MID_CODE) ? MID_CODE : scaled;
    endfunction

    // Sine sample for a timer count at the current frequency
    function automatic logic [SAMPLE_W-1:0] sine_level(input logic [TIMER_W-1:0] t);
        logic [63:0] period;
        logic [63:0] angle;
        logic [63:0] quadrant;
        logic [63:0] offset;
        logic [63:0] mag;
        if (freq_reg == '0)
            return SAMPLE_W'(MID_CODE);
        period = COUNTS_PER_SEC / 64'(freq_reg);
        // frequency above the clock rate: no usable period
        if (period == 64'd0)
            return SAMPLE_W'(MID_CODE);
        angle    = ((64'(t) % period) << PHASE_BITS) / period;
        quadrant = (angle >> (PHASE_BITS - 2)) & 64'd3;
        offset   = angle & ((64'd1 << (PHASE_BITS - 2)) - 64'd1);
        if (quadrant[0])
            offset = (64'd1 << (PHASE_BITS - 2)) - offset;
        mag = quarter_mag(offset);
        return quadrant[1] ? SAMPLE_W'(MID_CODE - mag) : SAMPLE_W'(MID_CODE + mag);
    endfunction

    // Advance the model by one accepted transaction and queue its sample, if any
    task automatic predict_tick(input logic ovf, input logic [TIMER_W-1:0] t);
        logic [RAMP_W-1:0] saw_next;
        if (!ovf)
            return;
        case (mode_reg)
            MODE_SINE:
                samples_due.push_back(sine_level(t));
            MODE_TRI:
            begin
                if (ramp_rising)
                begin
                    ramp_level = ramp_level + RAMP_W'(TRI_STEP);
                    if (ramp_level >= RAMP_W'(TOP_CODE))
                        ramp_rising = 1'b0;
                end
                else
                begin
                    ramp_level = (ramp_level >= RAMP_W'(TRI_STEP)) ?
                                 ramp_level - RAMP_W'(TRI_STEP) : '0;
                    if (ramp_level == '0)
                        ramp_rising = 1'b1;
                end
                samples_due.push_back((ramp_level > RAMP_W'(TOP_CODE)) ?
                                      SAMPLE_W'(TOP_CODE) : ramp_level[SAMPLE_W-1:0]);
            end
            MODE_SAW:
            begin
                // widened so the step past full scale is seen before the wrap
                saw_next  = {1'b0, saw_level} + RAMP_W'(SAW_INC);
                saw_level = (saw_next >= RAMP_W'(TOP_CODE)) ? '0 : saw_next[SAMPLE_W-1:0];
                samples_due.push_back(saw_level);
            end
            default:
                ;
        endcase
    endtask

    // Item driver: bursts of transactions separated by random gaps
    always @(posedge clk)
    begin : item_driver
        tick_t next_tick;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                predict_tick(overflow_event, timer_value);
                ticks_unaccepted--;
            end
            if (!item_valid || item_ready)
            begin
                if (gap_left != 0 || tick_queue.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    item_valid <= 1'b0;
                end
                else
                begin
                    next_tick = tick_queue.pop_front();
                    item_valid     <= 1'b1;
                    overflow_event <= next_tick.overflow;
                    timer_value    <= next_tick.timer;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = (send_style == 0) ? 1 : $urandom_range(1, 12);
                        case (send_style)
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 3);
                            default: gap_left = $urandom_range(4, 20);
                        endcase
                    end
                end
            end
        end
    end

    // Sample monitor and receiver stall pattern
    always @(posedge clk)
    begin : sample_monitor
        logic [SAMPLE_W-1:0] want;
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                if (samples_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: dac_sample expected none, got %0d", $time, dac_sample);
                end
                else
                begin
                    want = samples_due.pop_front();
                    if (dac_sample !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: dac_sample expected %0d, got %0d",
                                 $time, want, dac_sample);
                    end
                end
            end
            stall_phase++;
            case (accept_style)
                0:       sample_ready <= 1'b1;
                1:       sample_ready <= 1'($urandom_range(0, 1));
                default: sample_ready <= ((stall_phase % 11) < 4);
            endcase
        end
    end

    task automatic push_tick(input logic ovf, input logic [TIMER_W-1:0] t);
        tick_t item;
        item.overflow = ovf;
        item.timer    = t;
        tick_queue.push_back(item);
        ticks_unaccepted++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                             input logic [FREQ_W-1:0] reg_value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= reg_value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (reg_index == CFG_MODE)
            mode_reg = mode_t'(reg_value[1:0]);
        else
            freq_reg = reg_value;
        cfg_valid <= 1'b0;
    endtask

    // Mode word carries random upper bits, which the block should drop
    task automatic set_config(input mode_t mode, input logic [FREQ_W-1:0] freq);
        logic [FREQ_W-1:0] mode_word;
        mode_word      = FREQ_W'($urandom());
        mode_word[1:0] = mode;
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_FREQ, freq);
    endtask

    // Hold off until every transaction is in and every sample is out
    task automatic settle_all();
        while (ticks_unaccepted != 0 || samples_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [FREQ_W-1:0] pick_frequency();
        case ($urandom_range(0, 5))
            0:
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return FREQ_W'(1);
                    2:       return FREQ_W'(2000000);
                    3:       return FREQ_W'(2000001);
                    4:       return '1;
                    default: return FREQ_W'(30);
                endcase
            1:       return FREQ_W'($urandom_range(1, 2000000));
            2:       return FREQ_W'($urandom_range(1, 100));
            3:       return FREQ_W'($urandom_range(100, 5000));
            4:       return FREQ_W'($urandom());
            default: return FREQ_W'($urandom_range(5000, 500000));
        endcase
    endfunction

    // Random transactions for one phase; ignored events are sprinkled in as noise
    task automatic queue_random_ticks(input mode_t mode, output int unsigned useful);
        int unsigned      goal;
        logic             ovf;
        logic [TIMER_W-1:0] t;
        case (mode)
            MODE_SINE: goal = 60;
            MODE_TRI:  goal = 80;
            MODE_SAW:  goal = 140;
            default:   goal = 20;
        endcase
        useful = 0;
        while (useful < goal)
        begin
            ovf = ($urandom_range(0, 99) >= 12);
            case ($urandom_range(0, 9))
                0:       t = '0;
                1:       t = '1;
                default: t = TIMER_W'($urandom());
            endcase
            push_tick(ovf, t);
            if (ovf)
                useful++;
        end
        if (mode == MODE_OFF)
            useful = 0;
    endtask

    // Stimulus: directed corners first, then shuffled rounds of random phases
    initial
    begin : stimulus
        mode_t       round_modes[5];
        mode_t       held;
        int unsigned pick;
        int unsigned phase_ticks;
        int unsigned useful_total;
        useful_total = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: sine at 1000 Hz, phase extremes and period edges
        push_tick(1'b1, 16'h0000);
        push_tick(1'b1, 16'hFFFF);
        push_tick(1'b1, 16'd500);
        push_tick(1'b1, 16'd1000);
        push_tick(1'b1, 16'd1500);
        push_tick(1'b1, 16'd1999);
        push_tick(1'b0, 16'hFFFF);
        settle_all();

        set_config(MODE_TRI, 21'd1000);
        push_tick(1'b1, 16'h5555);
        push_tick(1'b1, 16'hAAAA);
        push_tick(1'b0, 16'h0000);
        push_tick(1'b1, 16'h0000);
        settle_all();

        set_config(MODE_SAW, '1);
        push_tick(1'b1, 16'h0000);
        push_tick(1'b1, 16'hFFFF);
        push_tick(1'b1, 16'h1234);
        settle_all();

        // no-output mode
        set_config(MODE_OFF, 21'd1000);
        push_tick(1'b1, 16'h0000);
        push_tick(1'b1, 16'hFFFF);
        settle_all();

        // zero frequency and frequencies at or past the clock rate
        set_config(MODE_SINE, '0);
        push_tick(1'b1, 16'h1234);
        push_tick(1'b1, 16'hFFFF);
        settle_all();
        set_config(MODE_SINE, '1);
        push_tick(1'b1, 16'hFFFF);
        settle_all();
        set_config(MODE_SINE, 21'd2000000);
        push_tick(1'b1, 16'hFFFF);
        settle_all();

        // period longer than the timer range
        set_config(MODE_SINE, 21'd1);
        push_tick(1'b1, 16'hFFFF);
        push_tick(1'b1, 16'h8000);
        settle_all();

        while (useful_total < TARGET_TICKS)
        begin
            round_modes = '{MODE_SINE, MODE_SINE, MODE_TRI, MODE_SAW, MODE_OFF};
            for (int i = 4; i > 0; i--)
            begin
                pick              = $urandom_range(0, i);
                held              = round_modes[i];
                round_modes[i]    = round_modes[pick];
                round_modes[pick] = held;
            end
            foreach (round_modes[i])
            begin
                send_style   = $urandom_range(0, 2);
                accept_style = $urandom_range(0, 2);
                set_config(round_modes[i], pick_frequency());
                queue_random_ticks(round_modes[i], phase_ticks);
                useful_total += phase_ticks;
                settle_all();
            end
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wfg_pkg.sv
rtl/wfg_div.sv
rtl/wfg_sine_rom.sv
rtl/wfg_datapath.sv
rtl/wfg_ctrl.sv
rtl/three_mode_waveform_generator_top.sv
tb/three_mode_waveform_generator_top_test.sv
